>>> design/error_rate_frequency_governor_defines.svh
// Assertion macros for the error rate frequency governor
`ifndef ERROR_RATE_FREQUENCY_GOVERNOR_DEFINES_SVH
`define ERROR_RATE_FREQUENCY_GOVERNOR_DEFINES_SVH
// Check that a condition implies a consequence in the same cycle
`define ERFG_ASSERT_IMP(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("implication check failed");
// Check that a condition implies a consequence in the next cycle
`define ERFG_ASSERT_NXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/erfg_pkg.sv
// Package with constants and types for the error rate frequency governor
`timescale 1ns / 1ps
package erfg_pkg;
  localparam int NumSteps = 64;
  localparam int StepW = $clog2(NumSteps);
  localparam int MaxNonces = 8;
  localparam int QW = 24;
  localparam logic [QW-1:0] QMax = '1;
  localparam logic [QW-1:0] QOne = 24'h010000;
  localparam logic [15:0] Decay = 16'd65208;
  localparam logic [QW-1:0] WeightEvidence = 24'd150 << 16;
  localparam logic [QW-1:0] WeightSupport = 24'd100 << 16;
  localparam int SmoothSpan = 20;
  // ceil(2^31 / 100): exact quotient by 100 for any 24-bit count after >> 31
  localparam logic [24:0] Recip100 = 25'd21474837;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_POLL  = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_DEFAULT_STEP = 3'd0,
    REG_TOP_STEP     = 3'd1,
    REG_MAX_RATE     = 3'd2,
    REG_HYST_BONUS   = 3'd3,
    REG_DROP_FRAC    = 3'd4,
    REG_NONCES       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [StepW-1:0] default_step;
    logic [StepW-1:0] top_step;
    logic [15:0]      max_rate;
    logic [15:0]      hyst_bonus;
    logic [15:0]      drop_frac;
    logic [3:0]       nonces;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] failures;
  } in_item_t;

  typedef struct packed {
    logic [5:0] step_index;
    logic       step_changed;
    logic       overheat_shutdown;
  } out_item_t;
endpackage

>>> design/erfg_if.sv
// Valid/ready channel interfaces for input and result transfers
`timescale 1ns / 1ps
interface erfg_in_if;
  import erfg_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface erfg_out_if;
  import erfg_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/erfg_ram.sv
// Generic single write, single read synchronous RAM with registered read data
`timescale 1ns / 1ps
module erfg_ram #(
  parameter int Width = 24,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/erfg_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module erfg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [47:0] quotient
);
  import erfg_pkg::*;
  logic [5:0]  count;
  logic [32:0] rem;
  logic [32:0] trial;
  logic [31:0] dsr;

  assign trial = {rem[31:0], quotient[47]} - {1'b0, dsr};

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 6'd47;
      rem <= '0;
      quotient <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial;
        quotient <= {quotient[46:0], 1'b1};
      end else begin
        rem <= {rem[31:0], quotient[47]};
        quotient <= {quotient[46:0], 1'b0};
      end
      count <= count - 6'd1;
      if (count == '0) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

>>> design/error_rate_frequency_governor.sv
// Error rate frequency governor: per-step statistics and step selection
// Poll: one division for the fractional failures; none with no step selected.
// Governor: a smoothing pass that divides where a step is raised, then limit,
// score and overheat walks over the steps.
// One item at a time; a held result does not block the next transfer in.
// Reset (rst high, synchronous) clears all three memories.
`timescale 1ns / 1ps
`include "error_rate_frequency_governor_defines.svh"
module error_rate_frequency_governor (
  input  logic           clk,
  input  logic           rst,
  erfg_in_if.sink        in_ch,
  erfg_out_if.source     out_ch,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import erfg_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_PRD, S_PWAIT, S_PWR, S_ERD, S_EWAIT, S_EDIV, S_EWR,
    S_SM_RD, S_SM_WAIT, S_SM_A, S_SM_DIV, S_SM_B, S_LIM_RD, S_LIM_WAIT, S_LIM_A,
    S_SC_RD, S_SC_WAIT, S_SC_A, S_SC_B, S_OH_RD, S_OH_WAIT, S_OH_A, S_OH_B, S_OUT
  } state_t;

  state_t          state;
  cfg_t            cfg;
  logic [6:0]      cur;
  logic [StepW:0]  idx;
  logic [StepW-1:0] top, def;
  logic [StepW-1:0] lim;
  logic            lim_phase;
  logic [StepW-1:0] best;
  logic [40:0]     best_score;
  logic            changed, hot;
  logic [3:0]      fails;
  logic [QW-1:0]   prev_peak;
  logic [QW-1:0]   rate_v;
  logic [QW-1:0]   cnt_v, wgt_v;
  logic [47:0]     prod_a, prod_b;
  logic [48:0]     cnt_scaled;
  logic [30:0]     sm_lhs, sm_rhs;
  logic            sm_raise;
  logic [22:0]     oh_bound;
  logic [40:0]     sc_val;

  // Memory ports
  logic            cnt_we, wgt_we, pk_we;
  logic [StepW-1:0] cnt_wa, wgt_wa, pk_wa, cnt_ra, wgt_ra, pk_ra;
  logic [QW-1:0]   cnt_wd, wgt_wd, pk_wd, cnt_rd, wgt_rd, pk_rd;

  erfg_ram #(.Width(QW), .Depth(NumSteps)) u_cnt (.clk, .we(cnt_we), .waddr(cnt_wa),
    .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
  erfg_ram #(.Width(QW), .Depth(NumSteps)) u_wgt (.clk, .we(wgt_we), .waddr(wgt_wa),
    .wdata(wgt_wd), .raddr(wgt_ra), .rdata(wgt_rd));
  erfg_ram #(.Width(QW), .Depth(NumSteps)) u_pk (.clk, .we(pk_we), .waddr(pk_wa),
    .wdata(pk_wd), .raddr(pk_ra), .rdata(pk_rd));

  // Divider for fractional failures, rate and smoothing
  logic        div_start, div_busy;
  logic [47:0] div_dd, div_q;
  logic [31:0] div_ds;
  erfg_div u_div (.clk, .rst, .start(div_start), .dividend(div_dd), .divisor(div_ds),
    .busy(div_busy), .quotient(div_q));

  logic cur_valid;
  assign cur_valid = (cur < 7'(NumSteps));
  assign in_ch.ready = (state == S_IDLE);

  // Clamp the step bounds
  always_comb begin
    top = (cfg.top_step > StepW'(NumSteps - 1)) ? StepW'(NumSteps - 1) : cfg.top_step;
    def = (cfg.default_step > top) ? top : cfg.default_step;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_step <= StepW'(32);
      cfg.top_step <= StepW'(63);
      cfg.max_rate <= 16'd3277;
      cfg.hyst_bonus <= 16'd6554;
      cfg.drop_frac <= 16'd26214;
      cfg.nonces <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT_STEP: cfg.default_step <= cfg_data[StepW-1:0];
        REG_TOP_STEP:     cfg.top_step <= cfg_data[StepW-1:0];
        REG_MAX_RATE:     cfg.max_rate <= cfg_data;
        REG_HYST_BONUS:   cfg.hyst_bonus <= cfg_data;
        REG_DROP_FRAC:    cfg.drop_frac <= cfg_data;
        REG_NONCES:       cfg.nonces <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Decay products, one multiply each for count and weight
  always_comb begin
    prod_a = 48'(cnt_v) * 48'(Decay);
    prod_b = 48'(wgt_v) * 48'(Decay);
  end

  // Count over 100 by reciprocal multiply
  assign cnt_scaled = 49'(cnt_rd) * 49'(Recip100);

  // Smoothing compare: peak[i+1] * i against peak[i] * (i + span)
  assign sm_lhs = 31'(pk_rd) * 31'(idx);
  assign sm_rhs = 31'(prev_peak) * 31'(idx + 7'(SmoothSpan));
  assign sm_raise = (sm_lhs < sm_rhs);

  // Overheat bound: (1 - drop fraction) times supported step
  assign oh_bound = 23'(17'(QOne) - 17'(cfg.drop_frac)) * 23'(lim);

  // Read addresses and write controls
  always_comb begin
    cnt_we = 1'b0; wgt_we = 1'b0; pk_we = 1'b0;
    cnt_wa = cur[StepW-1:0]; wgt_wa = cur[StepW-1:0]; pk_wa = cur[StepW-1:0];
    cnt_wd = '0; wgt_wd = '0; pk_wd = '0;
    cnt_ra = cur[StepW-1:0]; wgt_ra = idx[StepW-1:0]; pk_ra = idx[StepW-1:0];
    div_start = 1'b0;
    div_dd = '0; div_ds = '0;
    case (state)
      S_CLEAR: begin
        cnt_we = 1'b1; wgt_we = 1'b1; pk_we = 1'b1;
        cnt_wa = idx[StepW-1:0]; wgt_wa = idx[StepW-1:0]; pk_wa = idx[StepW-1:0];
      end
      S_PRD: begin
        wgt_ra = cur[StepW-1:0];
        div_start = 1'b1;
        div_dd = 48'(fails) << 16;
        div_ds = 32'((cfg.nonces == 4'd0) ? 4'd1 : cfg.nonces);
      end
      S_PWAIT: wgt_ra = cur[StepW-1:0];
      S_PWR: begin
        cnt_we = 1'b1; wgt_we = 1'b1;
        cnt_wd = (49'(prod_a >> 16) + 49'(div_q) > 49'(QMax)) ? QMax
               : QW'(49'(prod_a >> 16) + 49'(div_q));
        wgt_wd = (25'(prod_b >> 16) + 25'(QOne) > 25'(QMax)) ? QMax
               : QW'(25'(prod_b >> 16) + 25'(QOne));
      end
      S_ERD: begin
        wgt_ra = cur[StepW-1:0]; pk_ra = cur[StepW-1:0];
      end
      S_EWAIT: begin
        if (wgt_rd >= WeightSupport) begin
          div_start = 1'b1;
          div_dd = 48'(cnt_rd) << 16;
          div_ds = 32'(wgt_rd);
        end
      end
      S_EWR: begin
        if (rate_v > prev_peak) begin
          pk_we = 1'b1;
          pk_wd = rate_v;
        end
      end
      S_SM_WAIT: pk_ra = StepW'(idx + 1'b1);
      S_SM_A: begin
        pk_ra = StepW'(idx + 1'b1);
        if (sm_raise) begin
          if (idx == '0) begin
            // Step zero saturates the next entry
            pk_we = 1'b1;
            pk_wa = StepW'(idx + 1'b1);
            pk_wd = QMax;
          end else begin
            div_start = 1'b1;
            div_dd = 48'(sm_rhs);
            div_ds = 32'(idx);
          end
        end
      end
      S_SM_DIV: begin
        if (!div_busy) begin
          pk_we = 1'b1;
          pk_wa = StepW'(idx + 1'b1);
          pk_wd = (div_q > 48'(QMax)) ? QMax : div_q[QW-1:0];
        end
      end
      S_LIM_RD, S_LIM_WAIT, S_LIM_A: begin
        pk_ra = StepW'(lim + 1'b1); wgt_ra = lim;
      end
      S_OH_RD, S_OH_WAIT, S_OH_A: wgt_ra = StepW'(lim + 1'b1);
      default: ;
    endcase
  end

  // Throughput score of the step being walked
  always_comb begin
    logic [40:0] f;
    f = 41'({idx[StepW-1:0], 16'd0}) + 41'(QOne);
    if ({1'b0, idx} == {1'b0, cur}) f = f + 41'(cfg.hyst_bonus);
    sc_val = f * 41'(QOne - pk_rd);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      cur <= '1;
      out_ch.valid <= 1'b0;
    end else begin
      // Hold the result until its transfer; load a new one when free
      if (state == S_OUT && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == (StepW+1)'(NumSteps - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          changed <= 1'b0; hot <= 1'b0;
          if (in_ch.valid && in_ch.ready) begin
            fails <= in_ch.data.failures;
            case (cmd_t'(in_ch.data.command))
              CMD_START: begin cur <= '1; idx <= '0; state <= S_SM_RD; end
              CMD_POLL:  state <= cur_valid ? S_PRD : S_OUT;
              CMD_END:   begin idx <= '0; state <= cur_valid ? S_ERD : S_SM_RD; end
              default:   state <= S_OUT;
            endcase
          end
        end
        S_PRD: state <= S_PWAIT;
        S_PWAIT: begin
          cnt_v <= cnt_rd; wgt_v <= wgt_rd;
          if (!div_busy) state <= S_PWR;
        end
        S_PWR: state <= S_OUT;
        S_ERD: state <= S_EWAIT;
        S_EWAIT: begin
          prev_peak <= pk_rd;
          if (wgt_rd < WeightSupport) begin
            rate_v <= QW'(cnt_scaled[48:31]);
            state <= S_EWR;
          end else begin
            state <= S_EDIV;
          end
        end
        S_EDIV: begin
          if (!div_busy) begin
            rate_v <= (div_q > 48'(QMax)) ? QMax : div_q[QW-1:0];
            state <= S_EWR;
          end
        end
        S_EWR: begin idx <= '0; state <= S_SM_RD; end
        // Smoothing pass over pairs
        S_SM_RD: begin
          if (idx >= {1'b0, top}) begin
            lim <= '0; lim_phase <= 1'b0; state <= S_LIM_RD;
          end else state <= S_SM_WAIT;
        end
        S_SM_WAIT: begin prev_peak <= pk_rd; state <= S_SM_A; end
        S_SM_A: state <= (sm_raise && idx != '0) ? S_SM_DIV : S_SM_B;
        S_SM_DIV: if (!div_busy) state <= S_SM_B;
        S_SM_B: begin
          idx <= idx + 1'b1;
          state <= S_SM_RD;
        end
        // Find highest allowed step
        S_LIM_RD: state <= S_LIM_WAIT;
        S_LIM_WAIT: state <= S_LIM_A;
        S_LIM_A: begin
          if (!lim_phase && lim < def && pk_rd < QW'(cfg.max_rate)) begin
            lim <= lim + 1'b1; state <= S_LIM_RD;
          end else if (lim < top && wgt_rd > WeightEvidence && pk_rd < QW'(cfg.max_rate))
          begin
            lim_phase <= 1'b1; lim <= lim + 1'b1; state <= S_LIM_RD;
          end else begin
            idx <= '0; best <= '0; best_score <= '0; state <= S_SC_RD;
          end
        end
        // Score pass
        S_SC_RD: state <= S_SC_WAIT;
        S_SC_WAIT: state <= S_SC_A;
        S_SC_A: begin
          if (pk_rd < QOne && sc_val > best_score) begin
            best <= idx[StepW-1:0]; best_score <= sc_val;
          end
          state <= S_SC_B;
        end
        S_SC_B: begin
          if (idx[StepW-1:0] >= lim) begin
            changed <= ({1'b0, best} != cur);
            cur <= {1'b0, best};
            lim <= def;
            state <= S_OH_RD;
          end else begin
            idx <= idx + 1'b1; state <= S_SC_RD;
          end
        end
        // Supported step walk and overheat check
        S_OH_RD: state <= S_OH_WAIT;
        S_OH_WAIT: state <= S_OH_A;
        S_OH_A: begin
          if (lim < top && wgt_rd > WeightSupport) begin
            lim <= lim + 1'b1; state <= S_OH_RD;
          end else state <= S_OH_B;
        end
        S_OH_B: begin
          hot <= (23'({best, 16'd0}) < oh_bound) && ({1'b0, best} + 7'd1 < {1'b0, lim});
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.data.step_index <= cur_valid ? cur[5:0] : 6'd0;
            out_ch.data.step_changed <= changed;
            out_ch.data.overheat_shutdown <= hot;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ERFG_ASSERT_IMP(a_ready_idle, clk, rst, in_ch.ready, state == S_IDLE)
  `ERFG_ASSERT_NXT(a_out_after, clk, rst, state == S_OUT, out_ch.valid)
  `ERFG_ASSERT_IMP(a_no_clear_accept, clk, rst, state == S_CLEAR, !in_ch.ready)
  `ERFG_ASSERT_NXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
